/* design/obb_pkg.sv */
// ----------------------------------------------------------------------------
// obb_pkg
// Shared widths, types and functions of the oriented box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int COORD_BITS   = 24;
  localparam int ANGLE_BITS   = 16;
  localparam int EXTENT_BITS  = 20;
  localparam int CORDIC_START = 19899;
  localparam int UNIT_MAX     = 32767;
  localparam int CORDIC_PIPE  = 8;
  localparam int CORDIC_LAT   = CORDIC_PIPE + 1;

  localparam int DX_BITS  = COORD_BITS + 1;
  localparam int DOT_BITS = COORD_BITS + 17;
  localparam int PRJ_BITS = 32;
  localparam int MUL_BITS = EXTENT_BITS + PRJ_BITS;
  localparam int SUM_BITS = MUL_BITS + 2;
  localparam int CMP_BITS = (SUM_BITS > DOT_BITS + 15) ? SUM_BITS : DOT_BITS + 15;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [16:0] z;
    logic [1:0]         q;
  } cordic_t;

  typedef struct packed {
    logic signed [DX_BITS-1:0] dx;
    logic signed [DX_BITS-1:0] dy;
    logic [EXTENT_BITS-1:0]    hwa;
    logic [EXTENT_BITS-1:0]    hha;
    logic [EXTENT_BITS-1:0]    hwb;
    logic [EXTENT_BITS-1:0]    hhb;
  } geom_t;

  function automatic logic [15:0] angle_to16(logic [ANGLE_BITS-1:0] a);
    logic [31:0] t;
    t = 32'(a);
    if (ANGLE_BITS >= 16) begin
      return 16'(t >> (ANGLE_BITS - 16));
    end else begin
      return 16'(t << (16 - ANGLE_BITS));
    end
  endfunction

  function automatic logic signed [16:0] arc_tab(int i);
    unique case (i)
      0:       return 17'sd8192;
      1:       return 17'sd4836;
      2:       return 17'sd2555;
      3:       return 17'sd1297;
      4:       return 17'sd651;
      5:       return 17'sd326;
      6:       return 17'sd163;
      7:       return 17'sd81;
      8:       return 17'sd41;
      9:       return 17'sd20;
      10:      return 17'sd10;
      11:      return 17'sd5;
      12:      return 17'sd3;
      13:      return 17'sd1;
      14:      return 17'sd1;
      default: return 17'sd0;
    endcase
  endfunction

  function automatic cordic_t cordic_step(cordic_t a, int i);
    cordic_t r;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    dx = a.y >>> i;
    dy = a.x >>> i;
    r = a;
    if (a.z >= 0) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - arc_tab(i);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + arc_tab(i);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_unit(logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sd32767;
    end else if (v < -18'sd32767) begin
      return -16'sd32767;
    end else begin
      return 16'(v);
    end
  endfunction

endpackage

/* design/obb_if.sv */
// ----------------------------------------------------------------------------
// obb_req_if / obb_rsp_if
// Valid/ready channels for box pair requests and hit results.
// ----------------------------------------------------------------------------
interface obb_req_if;
  import obb_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] first_center_x;
  logic signed [COORD_BITS-1:0] first_center_y;
  logic [EXTENT_BITS-1:0]       first_half_width;
  logic [EXTENT_BITS-1:0]       first_half_height;
  logic [ANGLE_BITS-1:0]        first_angle;
  logic signed [COORD_BITS-1:0] second_center_x;
  logic signed [COORD_BITS-1:0] second_center_y;
  logic [EXTENT_BITS-1:0]       second_half_width;
  logic [EXTENT_BITS-1:0]       second_half_height;
  logic [ANGLE_BITS-1:0]        second_angle;
  modport source(output valid, first_center_x, first_center_y, first_half_width,
                 first_half_height, first_angle, second_center_x, second_center_y,
                 second_half_width, second_half_height, second_angle, input ready);
  modport sink(input valid, first_center_x, first_center_y, first_half_width,
               first_half_height, first_angle, second_center_x, second_center_y,
               second_half_width, second_half_height, second_angle, output ready);
endinterface

interface obb_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  modport source(output valid, hit, input ready);
  modport sink(input valid, hit, output ready);
endinterface

/* design/obb_cordic.sv */
// ----------------------------------------------------------------------------
// obb_cordic
// Pipelined sine/cosine: two CORDIC steps a stage, then clamp and quadrant.
// ----------------------------------------------------------------------------
module obb_cordic (
  input  logic                         clk,
  input  logic [obb_pkg::CORDIC_LAT-1:0] en,
  input  logic [15:0]                  angle,
  output logic signed [15:0]           cosv,
  output logic signed [15:0]           sinv
);
  import obb_pkg::*;

  cordic_t st [CORDIC_PIPE];
  cordic_t init;

  always_comb begin
    init.x = 18'(CORDIC_START);
    init.y = '0;
    init.z = 17'(angle[13:0]);
    init.q = angle[15:14];
  end

  for (genvar k = 0; k < CORDIC_PIPE; k++) begin : g_stage
    cordic_t src;
    if (k == 0) begin : g_first
      assign src = init;
    end else begin : g_rest
      assign src = st[k-1];
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k] <= cordic_step(cordic_step(src, 2 * k), 2 * k + 1);
      end
    end
  end

  logic signed [15:0] cs;
  logic signed [15:0] sn;
  assign cs = clamp_unit(st[CORDIC_PIPE-1].x);
  assign sn = clamp_unit(st[CORDIC_PIPE-1].y);

  always_ff @(posedge clk) begin
    if (en[CORDIC_PIPE]) begin
      unique case (st[CORDIC_PIPE-1].q)
        2'd0: begin cosv <= cs;  sinv <= sn;  end
        2'd1: begin cosv <= -sn; sinv <= cs;  end
        2'd2: begin cosv <= -cs; sinv <= -sn; end
        default: begin cosv <= sn; sinv <= -cs; end
      endcase
    end
  end
endmodule

/* design/obb_axis.sv */
// ----------------------------------------------------------------------------
// obb_axis
// Projects both boxes on four axes and compares centre gap with radii.
// ----------------------------------------------------------------------------
module obb_axis (
  input  logic               clk,
  input  logic [3:0]         en,
  input  logic signed [15:0] cosa,
  input  logic signed [15:0] sina,
  input  logic signed [15:0] cosb,
  input  logic signed [15:0] sinb,
  input  obb_pkg::geom_t     geom,
  output logic               hit
);
  import obb_pkg::*;

  logic signed [15:0] ux [4];
  logic signed [15:0] uy [4];
  logic signed [15:0] cv [4];
  logic signed [15:0] sv [4];

  logic signed [DOT_BITS-1:0] d_r [4];
  logic signed [PRJ_BITS-1:0] p_r [4][4];
  logic [EXTENT_BITS-1:0]     ext [4];
  logic [DOT_BITS-1:0]        dm [4];
  logic [MUL_BITS-1:0]        m_r [4][4];
  logic [DOT_BITS-1:0]        dm2 [4];
  logic [SUM_BITS-1:0]        s01 [4];
  logic [SUM_BITS-1:0]        s23 [4];
  logic [3:0]                 ok;

  always_comb begin
    ux[0] = cosa;  uy[0] = sina;
    ux[1] = -sina; uy[1] = cosa;
    ux[2] = cosb;  uy[2] = sinb;
    ux[3] = -sinb; uy[3] = cosb;
    cv[0] = cosa;  sv[0] = sina;
    cv[1] = -sina; sv[1] = cosa;
    cv[2] = cosb;  sv[2] = sinb;
    cv[3] = -sinb; sv[3] = cosb;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ext[0] <= geom.hwa;
      ext[1] <= geom.hha;
      ext[2] <= geom.hwb;
      ext[3] <= geom.hhb;
      for (int j = 0; j < 4; j++) begin
        d_r[j] <= DOT_BITS'(geom.dx) * DOT_BITS'(ux[j])
                + DOT_BITS'(geom.dy) * DOT_BITS'(uy[j]);
        for (int k = 0; k < 4; k++) begin
          p_r[j][k] <= PRJ_BITS'(cv[k]) * PRJ_BITS'(ux[j])
                     + PRJ_BITS'(sv[k]) * PRJ_BITS'(uy[j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < 4; j++) begin
        dm[j] <= d_r[j][DOT_BITS-1] ? DOT_BITS'(-d_r[j]) : DOT_BITS'(d_r[j]);
        for (int k = 0; k < 4; k++) begin
          m_r[j][k] <= MUL_BITS'(ext[k])
                     * MUL_BITS'(p_r[j][k][PRJ_BITS-1] ? -p_r[j][k] : p_r[j][k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 4; j++) begin
        dm2[j] <= dm[j];
        s01[j] <= SUM_BITS'(m_r[j][0]) + SUM_BITS'(m_r[j][1]);
        s23[j] <= SUM_BITS'(m_r[j][2]) + SUM_BITS'(m_r[j][3]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ok[j] = (CMP_BITS'(dm2[j]) << 15) <= (CMP_BITS'(s01[j]) + CMP_BITS'(s23[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hit <= &ok;
    end
  end
endmodule

/* design/obb_obb_overlap_test_core.sv */
// A request passes the input register, eight two-step CORDIC stages and five arithmetic stages.
// Throughput: one request per cycle unless stalled; a full stage holds only while the next one holds.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// obb_obb_overlap_test_core
// Separating axis overlap test of two oriented rectangles, fully pipelined.
// ----------------------------------------------------------------------------
module obb_obb_overlap_test_core (
  input logic       clk,
  input logic       rst,
  obb_req_if.sink   req,
  obb_rsp_if.source rsp
);
  import obb_pkg::*;

  localparam int NST = CORDIC_LAT + 5;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || rsp.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= req.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign req.ready = en[0];
  assign rsp.valid = vld[NST-1];

  logic [15:0] anga;
  logic [15:0] angb;
  geom_t       geom [CORDIC_LAT+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      anga          <= angle_to16(req.first_angle);
      angb          <= angle_to16(req.second_angle);
      geom[0].dx    <= DX_BITS'(req.second_center_x) - DX_BITS'(req.first_center_x);
      geom[0].dy    <= DX_BITS'(req.second_center_y) - DX_BITS'(req.first_center_y);
      geom[0].hwa   <= req.first_half_width;
      geom[0].hha   <= req.first_half_height;
      geom[0].hwb   <= req.second_half_width;
      geom[0].hhb   <= req.second_half_height;
    end
    for (int k = 1; k <= CORDIC_LAT; k++) begin
      if (en[k]) geom[k] <= geom[k-1];
    end
  end

  logic signed [15:0] cosa;
  logic signed [15:0] sina;
  logic signed [15:0] cosb;
  logic signed [15:0] sinb;

  obb_cordic u_cordic_a (
    .clk   (clk),
    .en    (en[CORDIC_LAT:1]),
    .angle (anga),
    .cosv  (cosa),
    .sinv  (sina)
  );

  obb_cordic u_cordic_b (
    .clk   (clk),
    .en    (en[CORDIC_LAT:1]),
    .angle (angb),
    .cosv  (cosb),
    .sinv  (sinb)
  );

  obb_axis u_axis (
    .clk  (clk),
    .en   (en[NST-1:CORDIC_LAT+1]),
    .cosa (cosa),
    .sina (sina),
    .cosb (cosb),
    .sinb (sinb),
    .geom (geom[CORDIC_LAT]),
    .hit  (rsp.hit)
  );

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld && !rsp.ready) |-> !req.ready)
    else $error("request taken while pipeline full and stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (int'($countones(vld)) == int'($past($countones(vld)))
      + int'($past(req.valid && req.ready)) - int'($past(rsp.valid && rsp.ready))))
    else $error("requests lost or duplicated in pipeline");

endmodule
